### design/res_pkg.sv
`timescale 1ns / 1ps
package res_pkg;

    localparam int ID_W = 20;
    localparam int CRED_W = 7;
    localparam int WAGE_W = 24;
    localparam int KEY_W = 24;
    localparam int TDATA_W = 80;
    localparam int DEF_MAX_RECORDS = 32;

    typedef struct packed {
        logic [WAGE_W-1:0] previous_wage;
        logic [WAGE_W-1:0] current_wage;
        logic [CRED_W-1:0] credibility;
        logic [ID_W-1:0]   record_id;
    } record_t;

    localparam int REC_W = $bits(record_t);

    localparam logic [1:0] KEY_CRED = 2'd0;
    localparam logic [1:0] KEY_CUR  = 2'd1;
    localparam logic [1:0] KEY_PREV = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SORT_INIT,
        OP_READ_I,
        OP_LOAD_A,
        OP_CMP,
        OP_WRITE_I,
        OP_OUT_INIT,
        OP_READ_K,
        OP_EMIT,
        OP_CLEAR
    } dp_op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_END_LOAD,
        C_FEW,
        C_MORE_J,
        C_MORE_I,
        C_EMPTY,
        C_OUT_STALL
    } cond_t;

    // MORE_K shares the jump slot of the step after EMIT
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        logic not_end_load;
        logic few;
        logic more_j;
        logic more_i;
        logic empty;
        logic out_stall;
        logic more_k;
    } cond_flags_t;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        logic   use_more_k;
        step_t  target;
    } uword_t;

    localparam step_t S_LOAD  = 4'd0;
    localparam step_t S_SI    = 4'd1;
    localparam step_t S_RDI   = 4'd2;
    localparam step_t S_LDA   = 4'd3;
    localparam step_t S_CMP   = 4'd4;
    localparam step_t S_WRI   = 4'd5;
    localparam step_t S_OI    = 4'd6;
    localparam step_t S_RDK   = 4'd7;
    localparam step_t S_EMIT  = 4'd8;
    localparam step_t S_STEPK = 4'd9;
    localparam step_t S_FIN   = 4'd10;

    localparam int NUM_STEPS = 11;

    localparam uword_t PROGRAM [NUM_STEPS] = '{
        '{OP_LOAD,      C_NOT_END_LOAD, 1'b0, S_LOAD},
        '{OP_SORT_INIT, C_FEW,          1'b0, S_OI},
        '{OP_READ_I,    C_NEVER,        1'b0, S_LOAD},
        '{OP_LOAD_A,    C_NEVER,        1'b0, S_LOAD},
        '{OP_CMP,       C_MORE_J,       1'b0, S_CMP},
        '{OP_WRITE_I,   C_MORE_I,       1'b0, S_RDI},
        '{OP_OUT_INIT,  C_EMPTY,        1'b0, S_FIN},
        '{OP_READ_K,    C_NEVER,        1'b0, S_LOAD},
        '{OP_EMIT,      C_OUT_STALL,    1'b0, S_EMIT},
        '{OP_NONE,      C_NEVER,        1'b1, S_RDK},
        '{OP_CLEAR,     C_ALWAYS,       1'b0, S_LOAD}
    };

    function automatic logic [KEY_W-1:0] get_key(input record_t r, input logic [1:0] sel);
        logic [KEY_W-1:0] k;
        case (sel)
            KEY_CUR:  k = r.current_wage;
            KEY_PREV: k = r.previous_wage;
            default:  k = {{(KEY_W-CRED_W){1'b0}}, r.credibility};
        endcase
        return k;
    endfunction

endpackage

### design/res_record_mem.sv
`timescale 1ns / 1ps
module res_record_mem
    import res_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_RECORDS,
    parameter int AW = $clog2(DEF_MAX_RECORDS)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  record_t       wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output record_t       rd_data
);

    record_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/res_sequencer.sv
`timescale 1ns / 1ps
module res_sequencer
    import res_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cond_flags_t flags,
    output uword_t      uword,
    output step_t       step
);

    step_t step_reg;
    step_t step_next;
    logic  take;

    always_comb
    begin
        if (step_reg < STEP_W'(NUM_STEPS))
        begin
            uword = PROGRAM[step_reg];
        end
        else
        begin
            uword = '{OP_NONE, C_ALWAYS, 1'b0, S_LOAD};
        end
    end

    always_comb
    begin
        case (uword.cond)
            C_NEVER:        take = 1'b0;
            C_ALWAYS:       take = 1'b1;
            C_NOT_END_LOAD: take = flags.not_end_load;
            C_FEW:          take = flags.few;
            C_MORE_J:       take = flags.more_j;
            C_MORE_I:       take = flags.more_i;
            C_EMPTY:        take = flags.empty;
            C_OUT_STALL:    take = flags.out_stall;
            default:        take = 1'b0;
        endcase
        if (uword.use_more_k)
        begin
            take = flags.more_k;
        end
        step_next = take ? uword.target : step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign step = step_reg;

endmodule

### design/record_exchange_sort_top.sv
`timescale 1ns / 1ps
// channel   dir  request                              handshake
// s_axis    in   tdata record, tlast last_record      tvalid/tready
// m_axis    out  tdata record, tlast out_last,        tvalid/tready
//                tuser overflow
// cfg       in   cfg_wdata key_select                 cfg_we, no wait
//
// Loading accepts one request per cycle. After the last one the exchange sort runs in
// the dual-port record memory: record i goes into a, is swapped with each later record
// of smaller key and is written back to i. Records are then read and emitted, held on
// m_axis stalls, and a clear step follows. s_axis_tready is high only while loading.
// rst_n clears counters, flags, key select and output valid; the memory is not cleared.
module record_exchange_sort_top
    import res_pkg::*;
#(
    parameter int MAX_RECORDS = DEF_MAX_RECORDS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // record_id[19:0], credibility[26:20], current_wage[50:27], previous_wage[74:51]
    input  logic [TDATA_W-1:0] s_axis_tdata,
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // out_id[19:0], out_credibility[26:20], out_current_wage[50:27],
    // out_previous_wage[74:51]
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tlast,
    // overflow[0]
    output logic               m_axis_tuser,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_wdata
);

    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int AW = $clog2(MAX_RECORDS);

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic          ovf_reg, ovf_next;
    logic [1:0]    key_sel_reg;
    record_t       a_reg, a_next;
    logic          out_valid_reg, out_valid_next;
    record_t       out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;
    logic          out_user_reg, out_user_next;

    uword_t        uword;
    step_t         step;
    cond_flags_t   flags;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    record_t       wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    record_t       rd_data;

    logic          s_acc;
    logic          out_free;
    logic          swap;
    logic [CW:0]   j_plus1;
    logic [CW:0]   i_plus2;
    logic [CW:0]   k_plus1;

    res_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .uword (uword),
        .step  (step)
    );

    res_record_mem #(
        .DEPTH (MAX_RECORDS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (uword.op == OP_LOAD);
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign j_plus1 = {1'b0, j_reg} + 1'b1;
    assign i_plus2 = {1'b0, i_reg} + (CW+1)'(2);
    assign k_plus1 = {1'b0, k_reg} + 1'b1;
    assign swap = get_key(a_reg, key_sel_reg) > get_key(rd_data, key_sel_reg);

    always_comb
    begin
        flags.not_end_load = !(s_acc && s_axis_tlast);
        flags.few = count_reg < CW'(2);
        flags.more_j = j_plus1 < {1'b0, count_reg};
        flags.more_i = i_plus2 < {1'b0, count_reg};
        flags.empty = count_reg == '0;
        flags.out_stall = !out_free;
        flags.more_k = k_reg < count_reg;
    end

    always_comb
    begin
        count_next = count_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        ovf_next = ovf_reg;
        a_next = a_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        out_user_next = out_user_reg;
        wr_en = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = a_reg;
        rd_en = 1'b0;
        rd_addr = i_reg[AW-1:0];

        case (uword.op)
            OP_LOAD:
            begin
                wr_data = s_axis_tdata[REC_W-1:0];
                if (s_acc)
                begin
                    if (count_reg < CW'(MAX_RECORDS))
                    begin
                        wr_en = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            OP_SORT_INIT:
            begin
                i_next = '0;
            end
            OP_READ_I:
            begin
                rd_en = 1'b1;
                rd_addr = i_reg[AW-1:0];
                j_next = i_reg + 1'b1;
            end
            OP_LOAD_A:
            begin
                a_next = rd_data;
                rd_en = 1'b1;
                rd_addr = j_reg[AW-1:0];
            end
            OP_CMP:
            begin
                if (swap)
                begin
                    wr_en = 1'b1;
                    wr_addr = j_reg[AW-1:0];
                    a_next = rd_data;
                end
                rd_en = 1'b1;
                rd_addr = j_plus1[AW-1:0];
                j_next = j_plus1[CW-1:0];
            end
            OP_WRITE_I:
            begin
                wr_en = 1'b1;
                wr_addr = i_reg[AW-1:0];
                i_next = i_reg + 1'b1;
            end
            OP_OUT_INIT:
            begin
                k_next = '0;
            end
            OP_READ_K:
            begin
                rd_en = 1'b1;
                rd_addr = k_reg[AW-1:0];
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = rd_data;
                    out_last_next = k_plus1 == {1'b0, count_reg};
                    out_user_next = ovf_reg;
                    k_next = k_plus1[CW-1:0];
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
                ovf_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            ovf_reg <= 1'b0;
            key_sel_reg <= KEY_CRED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
            ovf_reg <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                key_sel_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {{(TDATA_W-REC_W){1'b0}}, out_data_reg};
    assign m_axis_tlast = out_last_reg;
    assign m_axis_tuser = out_user_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RECORDS))
        else $error("record count above capacity");

    a_cmp_order: assert property (@(posedge clk) disable iff (!rst_n)
        (uword.op == OP_CMP) |-> (i_reg < j_reg) && (j_reg < count_reg))
        else $error("compare indexes out of order");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (step == S_EMIT && out_free) |-> (k_reg < count_reg))
        else $error("emit index beyond stored records");

    a_no_load_while_sorting: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_axis_tlast) |=> !s_axis_tready)
        else $error("input accepted after last record");

endmodule
